// File: hdl/assert_macros.svh
// Assertion macros shared by the files that carry concurrent checks.
// Depends on nothing; every macro samples on the given clock with reset excluded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/id3_pkg.sv
// Shared types and constants of the ID3v2 tag deframer.
// Depends on nothing; used by the front parser, the result queue and the top level.
package id3_pkg;

    localparam int SEGMENT_BITS = 8;
    localparam int SEG_LIMIT_INT = ((1 << SEGMENT_BITS) - 1) > 255 ? 255
                                   : ((1 << SEGMENT_BITS) - 1);
    localparam logic [7:0] SEG_LIMIT = SEG_LIMIT_INT[7:0];

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_TAG_HDR   = 2'd0,
        KIND_FRAME_HDR = 2'd1,
        KIND_BODY      = 2'd2,
        KIND_TAG_END   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  version_major;
        logic [7:0]  version_revision;
        logic [3:0]  tag_flag_bits;
        logic [27:0] tag_length;
        logic [31:0] frame_ident;
        logic [27:0] frame_length;
        logic [15:0] frame_flag_word;
        logic [7:0]  body_value;
        logic [27:0] body_offset;
        logic [7:0]  segment_number;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t item;
    } wr_t;

    typedef struct packed {
        logic    full;
        logic    empty;
        result_t head;
    } q_status_t;

endpackage

// File: hdl/id3v2_tag_deframer.sv
// Top level of the ID3v2.4 tag deframer: parser front, result queue and checks.
// Depends on id3_pkg, id3_front, id3_queue and assert_macros.svh.

// The block takes one tag byte per clock cycle and never stalls for its own work:
// each byte is classified and its result item, if any, is formed in the same cycle
// by the parser and written into a four-entry result queue. Input is refused (full
// high) only while that queue holds four unread items, so a consumer that pops in
// every cycle sees a sustained rate of one byte per cycle. Each result is registered
// in the queue and shows on the output once all items ahead of it are popped. After
// the tag end item the block ignores all further bytes until reset.
`include "assert_macros.svh"

module id3v2_tag_deframer
    import id3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  version_major,
    output logic [7:0]  version_revision,
    output logic [3:0]  tag_flag_bits,
    output logic [27:0] tag_length,
    output logic [31:0] frame_ident,
    output logic [27:0] frame_length,
    output logic [15:0] frame_flag_word,
    output logic [7:0]  body_value,
    output logic [27:0] body_offset,
    output logic [7:0]  segment_number,
    output logic        last
);

    wr_t       wr;
    q_status_t status;
    logic      accept;
    logic      head_is_end;
    logic      frame_fields_clear;
    logic      last_matches;

    assign accept = push && !status.full;

    id3_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .wr      (wr)
    );

    id3_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd     (pop),
        .status (status)
    );

    assign full             = status.full;
    assign empty            = status.empty;
    assign kind             = status.head.kind;
    assign version_major    = status.head.version_major;
    assign version_revision = status.head.version_revision;
    assign tag_flag_bits    = status.head.tag_flag_bits;
    assign tag_length       = status.head.tag_length;
    assign frame_ident      = status.head.frame_ident;
    assign frame_length     = status.head.frame_length;
    assign frame_flag_word  = status.head.frame_flag_word;
    assign body_value       = status.head.body_value;
    assign body_offset      = status.head.body_offset;
    assign segment_number   = status.head.segment_number;
    assign last             = status.head.last;

    assign head_is_end        = !empty && (kind == KIND_TAG_END);
    assign frame_fields_clear = (frame_ident == 32'd0) && (frame_length == 28'd0)
                                && (body_value == 8'd0);
    assign last_matches       = (({1'b0, body_offset} + 29'd1) == {1'b0, frame_length});

    `ASSERT_SAME(a_no_write_when_refused, clk, rst_n, !accept, !wr.valid)
    `ASSERT_SAME(a_tag_end_no_frame, clk, rst_n, head_is_end, frame_fields_clear)
    `ASSERT_SAME(a_last_at_frame_end, clk, rst_n, !empty && last, last_matches)
    `ASSERT_NEXT(a_item_kept, clk, rst_n, wr.valid && accept && !pop, !empty)

endmodule

// File: hdl/id3_front.sv
// Front parser: accepts one tag byte a cycle while accept is high, tracks the header
// and frame state and produces at most one result item per byte. Depends on id3_pkg.
module id3_front
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output wr_t        wr
);

    typedef enum logic [2:0] {
        PH_TAG_HDR   = 3'd0,
        PH_EXT_SIZE  = 3'd1,
        PH_EXT_SKIP  = 3'd2,
        PH_FRAME_HDR = 3'd3,
        PH_BODY      = 3'd4,
        PH_DONE      = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pc_reg, pc_next;
    logic [15:0] ver_reg, ver_next;
    logic [3:0]  tflags_reg, tflags_next;
    logic [27:0] tsize_reg, tsize_next;
    logic [27:0] consumed_reg, consumed_next;
    logic [27:0] skip_reg, skip_next;
    logic [31:0] fid_reg, fid_next;
    logic [27:0] fsize_reg, fsize_next;
    logic [15:0] fflags_reg, fflags_next;
    logic [27:0] bp_reg, bp_next;
    logic [7:0]  nul_reg, nul_next;

    logic        res_valid;
    kind_t       res_kind;
    logic        with_frame;
    logic [7:0]  res_value;
    logic [27:0] res_offset;
    logic [7:0]  res_segment;
    logic        res_last;
    logic [28:0] bp_inc;
    logic [27:0] skip_shift;
    logic [27:0] skip_dec;
    logic [31:0] fid_base;
    logic [27:0] fsize_base;
    logic [15:0] fflags_base;

    always_comb
    begin
        phase_next    = phase_reg;
        pc_next       = pc_reg;
        ver_next      = ver_reg;
        tflags_next   = tflags_reg;
        tsize_next    = tsize_reg;
        consumed_next = consumed_reg;
        skip_next     = skip_reg;
        fid_next      = fid_reg;
        fsize_next    = fsize_reg;
        fflags_next   = fflags_reg;
        bp_next       = bp_reg;
        nul_next      = nul_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_TAG_HDR;
        with_frame    = 1'b0;
        res_value     = 8'd0;
        res_offset    = 28'd0;
        res_segment   = 8'd0;
        res_last      = 1'b0;
        bp_inc        = {1'b0, bp_reg} + 29'd1;
        skip_shift    = {skip_reg[20:0], in_byte[6:0]};
        skip_dec      = (skip_reg == 28'd0) ? 28'd0 : skip_reg - 28'd1;
        fid_base      = (pc_reg == 4'd0) ? 32'd0 : fid_reg;
        fsize_base    = (pc_reg == 4'd0) ? 28'd0 : fsize_reg;
        fflags_base   = (pc_reg == 4'd0) ? 16'd0 : fflags_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_TAG_HDR:
                begin
                    if (pc_reg == 4'd3)
                        ver_next[15:8] = in_byte;
                    else if (pc_reg == 4'd4)
                        ver_next[7:0] = in_byte;
                    else if (pc_reg == 4'd5)
                        tflags_next = in_byte[7:4];
                    else if (pc_reg >= 4'd6)
                        tsize_next = {tsize_reg[20:0], in_byte[6:0]};
                    if (pc_reg >= 4'd9)
                    begin
                        phase_next    = tflags_reg[2] ? PH_EXT_SIZE : PH_FRAME_HDR;
                        pc_next       = 4'd0;
                        consumed_next = 28'd0;
                        skip_next     = 28'd0;
                        res_valid     = 1'b1;
                        res_kind      = KIND_TAG_HDR;
                    end
                    else
                    begin
                        pc_next = pc_reg + 4'd1;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    if (consumed_reg >= tsize_reg ||
                        (phase_reg == PH_FRAME_HDR && pc_reg == 4'd0 && in_byte == 8'd0))
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res_kind   = KIND_TAG_END;
                    end
                    else
                    begin
                        consumed_next = consumed_reg + 28'd1;
                        case (phase_reg)
                            PH_EXT_SIZE:
                            begin
                                if (pc_reg >= 4'd3)
                                begin
                                    skip_next  = (skip_shift >= 28'd4) ? skip_shift - 28'd4
                                                                       : 28'd0;
                                    phase_next = (skip_shift > 28'd4) ? PH_EXT_SKIP
                                                                      : PH_FRAME_HDR;
                                    pc_next    = 4'd0;
                                end
                                else
                                begin
                                    skip_next = skip_shift;
                                    pc_next   = pc_reg + 4'd1;
                                end
                            end
                            PH_EXT_SKIP:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == 28'd0)
                                begin
                                    phase_next = PH_FRAME_HDR;
                                    pc_next    = 4'd0;
                                end
                            end
                            PH_FRAME_HDR:
                            begin
                                fid_next    = fid_base;
                                fsize_next  = fsize_base;
                                fflags_next = fflags_base;
                                if (pc_reg < 4'd4)
                                    fid_next = {fid_base[23:0], in_byte};
                                else if (pc_reg < 4'd8)
                                    fsize_next = {fsize_base[20:0], in_byte[6:0]};
                                else
                                    fflags_next = {fflags_base[7:0], in_byte};
                                if (pc_reg >= 4'd9)
                                begin
                                    bp_next    = 28'd0;
                                    nul_next   = 8'd0;
                                    pc_next    = 4'd0;
                                    phase_next = (fsize_base != 28'd0) ? PH_BODY
                                                                       : PH_FRAME_HDR;
                                    res_valid  = 1'b1;
                                    res_kind   = KIND_FRAME_HDR;
                                    with_frame = 1'b1;
                                end
                                else
                                begin
                                    pc_next = pc_reg + 4'd1;
                                end
                            end
                            default:
                            begin
                                res_valid   = 1'b1;
                                res_kind    = KIND_BODY;
                                with_frame  = 1'b1;
                                res_value   = in_byte;
                                res_offset  = bp_reg;
                                res_segment = nul_reg;
                                res_last    = (bp_inc == {1'b0, fsize_reg});
                                if (in_byte == 8'd0 && nul_reg < SEG_LIMIT)
                                    nul_next = nul_reg + 8'd1;
                                bp_next = bp_inc[27:0];
                                if (bp_inc >= {1'b0, fsize_reg})
                                begin
                                    phase_next = PH_FRAME_HDR;
                                    pc_next    = 4'd0;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        wr.valid                 = res_valid;
        wr.item.kind             = res_kind;
        wr.item.version_major    = ver_next[15:8];
        wr.item.version_revision = ver_next[7:0];
        wr.item.tag_flag_bits    = tflags_next;
        wr.item.tag_length       = tsize_next;
        wr.item.frame_ident      = with_frame ? fid_next : 32'd0;
        wr.item.frame_length     = with_frame ? fsize_next : 28'd0;
        wr.item.frame_flag_word  = with_frame ? fflags_next : 16'd0;
        wr.item.body_value       = res_value;
        wr.item.body_offset      = res_offset;
        wr.item.segment_number   = res_segment;
        wr.item.last             = res_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG_HDR;
            pc_reg       <= 4'd0;
            ver_reg      <= 16'd0;
            tflags_reg   <= 4'd0;
            tsize_reg    <= 28'd0;
            consumed_reg <= 28'd0;
            skip_reg     <= 28'd0;
            fid_reg      <= 32'd0;
            fsize_reg    <= 28'd0;
            fflags_reg   <= 16'd0;
            bp_reg       <= 28'd0;
            nul_reg      <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pc_reg       <= pc_next;
            ver_reg      <= ver_next;
            tflags_reg   <= tflags_next;
            tsize_reg    <= tsize_next;
            consumed_reg <= consumed_next;
            skip_reg     <= skip_next;
            fid_reg      <= fid_next;
            fsize_reg    <= fsize_next;
            fflags_reg   <= fflags_next;
            bp_reg       <= bp_next;
            nul_reg      <= nul_next;
        end
    end

endmodule

// File: hdl/id3_queue.sv
// Result queue: a short first-in first-out store between the parser and the result side.
// Depends on id3_pkg.
module id3_queue
    import id3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  wr_t       wr,
    input  logic      rd,
    output q_status_t status
);

    result_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wp_reg;
    logic [QUEUE_AW-1:0]   rp_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head  = mem[rp_reg];
    assign do_wr        = wr.valid && !status.full;
    assign do_rd        = rd && !status.empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr.item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the ID3v2.4 tag deframer: one tag is streamed byte by byte.
// Depends on id3_pkg and the id3v2_tag_deframer RTL; a scoreboard class predicts each item.
`timescale 1ns / 1ps

module tb_top
    import id3_pkg::*;
();

    localparam int ITEM_TARGET = 1880;
    localparam int TRAIL_BYTES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_AT = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LO = 600;
    localparam int QUIET_HI = 1000;

    typedef enum logic [2:0] {
        P_HEADER,
        P_EXT_SIZE,
        P_EXT_SKIP,
        P_FRAME_HDR,
        P_BODY,
        P_DONE
    } parse_phase_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [7:0]  version_major;
    logic [7:0]  version_revision;
    logic [3:0]  tag_flag_bits;
    logic [27:0] tag_length;
    logic [31:0] frame_ident;
    logic [27:0] frame_length;
    logic [15:0] frame_flag_word;
    logic [7:0]  body_value;
    logic [27:0] body_offset;
    logic [7:0]  segment_number;
    logic        last;

    id3v2_tag_deframer dut (.*);

    class deframe_scoreboard;
        parse_phase_t phase;
        logic [3:0]   step;
        logic [7:0]   ver_major;
        logic [7:0]   ver_rev;
        logic [3:0]   flags;
        logic [27:0]  tag_len;
        logic [27:0]  consumed;
        logic [27:0]  skip_left;
        logic [31:0]  frame_id;
        logic [27:0]  frame_len;
        logic [15:0]  frame_flags;
        logic [27:0]  position;
        logic [7:0]   nuls;
        result_t      expected_items[$];
        int           mismatches;
        int           checked;
        int           peak_segment;

        function new();
            phase = P_HEADER;
            step = '0;
            ver_major = '0;
            ver_rev = '0;
            flags = '0;
            tag_len = '0;
            consumed = '0;
            skip_left = '0;
            frame_id = '0;
            frame_len = '0;
            frame_flags = '0;
            position = '0;
            nuls = '0;
            mismatches = 0;
            checked = 0;
            peak_segment = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t r;
            bit      emit;
            r = '0;
            emit = 1'b0;
            case (phase)
                P_DONE: ;
                P_HEADER:
                begin
                    if (step == 4'd3)
                        ver_major = b;
                    else if (step == 4'd4)
                        ver_rev = b;
                    else if (step == 4'd5)
                        flags = b[7:4];
                    else if (step >= 4'd6)
                        tag_len = {tag_len[20:0], b[6:0]};
                    if (step >= 4'd9)
                    begin
                        phase = flags[2] ? P_EXT_SIZE : P_FRAME_HDR;
                        step = '0;
                        consumed = '0;
                        skip_left = '0;
                        r.kind = KIND_TAG_HDR;
                        emit = 1'b1;
                    end
                    else
                        step++;
                end
                default:
                begin
                    if (consumed >= tag_len || (phase == P_FRAME_HDR && step == 4'd0
                                                && b == 8'h00))
                    begin
                        phase = P_DONE;
                        r.kind = KIND_TAG_END;
                        emit = 1'b1;
                    end
                    else
                    begin
                        consumed++;
                        case (phase)
                            P_EXT_SIZE:
                            begin
                                skip_left = {skip_left[20:0], b[6:0]};
                                if (step >= 4'd3)
                                begin
                                    skip_left = (skip_left >= 28'd4) ? skip_left - 28'd4 : '0;
                                    phase = (skip_left != '0) ? P_EXT_SKIP : P_FRAME_HDR;
                                    step = '0;
                                end
                                else
                                    step++;
                            end
                            P_EXT_SKIP:
                            begin
                                if (skip_left != '0)
                                    skip_left--;
                                if (skip_left == '0)
                                begin
                                    phase = P_FRAME_HDR;
                                    step = '0;
                                end
                            end
                            P_FRAME_HDR:
                            begin
                                if (step == 4'd0)
                                begin
                                    frame_id = '0;
                                    frame_len = '0;
                                    frame_flags = '0;
                                end
                                if (step < 4'd4)
                                    frame_id = {frame_id[23:0], b};
                                else if (step < 4'd8)
                                    frame_len = {frame_len[20:0], b[6:0]};
                                else
                                    frame_flags = {frame_flags[7:0], b};
                                if (step >= 4'd9)
                                begin
                                    position = '0;
                                    nuls = '0;
                                    step = '0;
                                    phase = (frame_len != '0) ? P_BODY : P_FRAME_HDR;
                                    r.kind = KIND_FRAME_HDR;
                                    r.frame_ident = frame_id;
                                    r.frame_length = frame_len;
                                    r.frame_flag_word = frame_flags;
                                    emit = 1'b1;
                                end
                                else
                                    step++;
                            end
                            default:
                            begin
                                r.kind = KIND_BODY;
                                r.frame_ident = frame_id;
                                r.frame_length = frame_len;
                                r.frame_flag_word = frame_flags;
                                r.body_value = b;
                                r.body_offset = position;
                                r.segment_number = nuls;
                                r.last = (29'(position) + 29'd1) == 29'(frame_len);
                                if (int'(nuls) > peak_segment)
                                    peak_segment = int'(nuls);
                                if (b == 8'h00 && nuls < SEG_LIMIT)
                                    nuls++;
                                position++;
                                if (position >= frame_len)
                                begin
                                    phase = P_FRAME_HDR;
                                    step = '0;
                                end
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
            if (emit)
            begin
                r.version_major = ver_major;
                r.version_revision = ver_rev;
                r.tag_flag_bits = flags;
                r.tag_length = tag_len;
                expected_items.insert(expected_items.size(), r);
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 50)
                $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("item %0d, %s: got 0x%0h, expected 0x%0h",
                                 checked, name, got_v, want_v));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_items.size() == 0)
            begin
                report($sformatf("result item of kind %0d with none outstanding", got.kind));
                return;
            end
            want = expected_items.pop_front();
            checked++;
            check_field("kind", 32'(got.kind), 32'(want.kind));
            check_field("version_major", 32'(got.version_major), 32'(want.version_major));
            check_field("version_revision", 32'(got.version_revision),
                        32'(want.version_revision));
            check_field("tag_flag_bits", 32'(got.tag_flag_bits), 32'(want.tag_flag_bits));
            check_field("tag_length", 32'(got.tag_length), 32'(want.tag_length));
            check_field("frame_ident", got.frame_ident, want.frame_ident);
            check_field("frame_length", 32'(got.frame_length), 32'(want.frame_length));
            check_field("frame_flag_word", 32'(got.frame_flag_word),
                        32'(want.frame_flag_word));
            check_field("body_value", 32'(got.body_value), 32'(want.body_value));
            check_field("body_offset", 32'(got.body_offset), 32'(want.body_offset));
            check_field("segment_number", 32'(got.segment_number),
                        32'(want.segment_number));
            check_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    deframe_scoreboard sb = new();
    logic [7:0] body_q[$];
    int         frame_total;
    int         empty_frames;
    int         sent_count;
    int         stall_cycles;
    int         cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles.", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit idle_roll();
        return $urandom_range(0, 99) < 31;
    endfunction

    function automatic void append_byte(logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endfunction

    function automatic logic [7:0] syncsafe_byte(int unsigned v, int idx);
        logic [7:0] b;
        b = 8'((v >> ((3 - idx) * 7)) & 32'h7F);
        b[7] = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic void add_frame(logic [31:0] id, int unsigned size, logic [15:0] fl,
                                      int zero_pct);
        for (int i = 0; i < 4; i++)
            append_byte(id[31 - 8 * i -: 8]);
        for (int i = 0; i < 4; i++)
            append_byte(syncsafe_byte(size, i));
        append_byte(fl[15:8]);
        append_byte(fl[7:0]);
        for (int unsigned i = 0; i < size; i++)
            append_byte(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom));
        frame_total++;
        if (size == 0)
            empty_frames++;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (!(sent_count >= QUIET_LO && sent_count < QUIET_HI) && idle_roll())
            begin
                push <= 1'b0;
                in_byte <= 8'($urandom);
            end
            else
            begin
                push <= 1'b1;
                in_byte <= b;
            end
            @(posedge clk);
            if (push && full)
                stall_cycles++;
            if (push && !full)
            begin
                sb.note_byte(in_byte);
                sent_count++;
                taken = 1'b1;
            end
        end
    endtask

    initial
    begin
        result_t got;
        int      hold_left;
        int      popped;
        bit      hold_done;
        pop = 1'b0;
        hold_left = 0;
        popped = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= !(!(popped >= QUIET_LO && popped < QUIET_HI) && idle_roll());
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind = kind_t'(kind);
                got.version_major = version_major;
                got.version_revision = version_revision;
                got.tag_flag_bits = tag_flag_bits;
                got.tag_length = tag_length;
                got.frame_ident = frame_ident;
                got.frame_length = frame_length;
                got.frame_flag_word = frame_flag_word;
                got.body_value = body_value;
                got.body_offset = body_offset;
                got.segment_number = segment_number;
                got.last = last;
                sb.check_result(got);
                popped++;
                if (!hold_done && popped == HOLD_AT)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
        end
    end

    initial
    begin
        int unsigned ext_size;
        int unsigned tag_len_val;
        int unsigned cut_len;
        int unsigned last_len;
        int unsigned fsize;
        int unsigned tag_bytes;
        int          pick;
        int          drain;
        logic [7:0]  flag_byte;
        logic [7:0]  corner_bytes[6];
        bit          by_size;
        bit          with_ext;
        bit          saturation_done;

        rst_n = 1'b0;
        push = 1'b0;
        in_byte = 8'h00;
        frame_total = 0;
        empty_frames = 0;
        sent_count = 0;
        stall_cycles = 0;
        corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h01};
        saturation_done = 1'b0;
        last_len = 0;

        with_ext = 1'($urandom_range(0, 1));
        by_size = 1'($urandom_range(0, 1));
        if (with_ext)
        begin
            ext_size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
            for (int i = 0; i < 4; i++)
                append_byte(syncsafe_byte(ext_size, i));
            for (int unsigned i = 4; i < ext_size; i++)
                append_byte(8'($urandom));
        end

        add_frame(32'h0100_0000, 0, 16'h0000, 0);
        add_frame(32'hFFFF_FFFF, 6, 16'hFFFF, 0);
        foreach (corner_bytes[k])
            body_q[body_q.size() - 6 + k] = corner_bytes[k];

        while (body_q.size() < ITEM_TARGET)
        begin
            last_len = body_q.size();
            if (!saturation_done && body_q.size() > ITEM_TARGET / 3)
            begin
                add_frame({8'($urandom_range(1, 255)), 24'($urandom)}, 300, 16'($urandom), 95);
                saturation_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    fsize = 0;
                else if (pick < 85)
                    fsize = $urandom_range(1, 24);
                else
                    fsize = $urandom_range(25, 100);
                add_frame({8'($urandom_range(1, 255)), 24'($urandom)}, fsize, 16'($urandom), 20);
            end
            last_len = body_q.size() - last_len;
        end

        // A size-limited tag may cut the last frame short; otherwise padding ends it.
        if (by_size)
        begin
            cut_len = $urandom_range(body_q.size() - last_len, body_q.size());
            while (body_q.size() > cut_len)
                void'(body_q.pop_back());
            tag_len_val = cut_len;
            append_byte(8'($urandom));
        end
        else
        begin
            tag_len_val = $urandom_range(0, 1) ? 32'h0FFF_FFFF
                                               : body_q.size() + 1 + $urandom_range(0, 4000);
            append_byte(8'h00);
        end
        tag_bytes = body_q.size();
        repeat (TRAIL_BYTES)
            append_byte(8'($urandom));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        repeat (5)
            send_byte(8'($urandom));
        flag_byte = 8'($urandom);
        flag_byte[6] = with_ext;
        send_byte(flag_byte);
        for (int i = 0; i < 4; i++)
            send_byte(syncsafe_byte(tag_len_val, i));
        foreach (body_q[k])
            send_byte(body_q[k]);
        @(negedge clk);
        push <= 1'b0;

        drain = 0;
        while (sb.expected_items.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (sb.expected_items.size() != 0)
            sb.report($sformatf("%0d result items never arrived", sb.expected_items.size()));

        $display("Streamed %0d tag bytes and %0d ignored trailing bytes; %0d items checked.",
                 tag_bytes + 10, TRAIL_BYTES, sb.checked);
        $display("Tag ended by %s, extended header %s, %0d frames (%0d empty), %s",
                 by_size ? "size" : "padding", with_ext ? "present" : "absent",
                 frame_total, empty_frames,
                 $sformatf("%0d input stall cycles, peak segment %0d.",
                           stall_cycles, sb.peak_segment));
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
